@@ src/traffic_light_ring_sequencer_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the traffic light ring sequencer
// Short forms for the concurrent checks used in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_RING_SEQUENCER_MACROS_SVH
`define TRAFFIC_LIGHT_RING_SEQUENCER_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define TLRS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the trigger holds, the consequence must hold at the next clock edge.
`define TLRS_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tlrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic light ring sequencer package
// Shared widths, register indexes, colour codes and the cell command type.
// ----------------------------------------------------------------------------
package tlrs_pkg;

    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 5;
    localparam int IDX_W      = 4;
    localparam int COL_W      = 2;
    localparam int PHASE_W    = 12;
    localparam int PACK_W     = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 2'd2;

    // Register reset values.
    localparam logic [LEN_W-1:0]   RST_LIGHT_COUNT = 5'd4;
    localparam logic [PHASE_W-1:0] RST_SHORT_TICKS = 12'd300;
    localparam logic [PHASE_W-1:0] RST_LONG_TICKS  = 12'd600;

    // Colour codes; the sequence advances by adding one modulo four.
    localparam logic [COL_W-1:0] COL_RED       = 2'd0;
    localparam logic [COL_W-1:0] COL_RED_AMBER = 2'd1;
    localparam logic [COL_W-1:0] COL_GREEN     = 2'd2;
    localparam logic [COL_W-1:0] COL_AMBER     = 2'd3;

    // Input item kinds.
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SWITCH = 1'b1;

    // Operations broadcast to the row of light cells. Only the cell that
    // holds the active token acts on them.
    typedef enum logic [1:0] {
        OP_NONE     = 2'd0,
        OP_ADVANCE  = 2'd1,
        OP_RED_PASS = 2'd2,
        OP_GREEN    = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_cmd;

endpackage

@@ src/tlrs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic light ring cell
// Holds the colour of one light and the active token, passes the token on.
// ----------------------------------------------------------------------------
module tlrs_cell
    import tlrs_pkg::*;
#(
    // Set on the cell that holds the active token after reset.
    parameter bit HOME = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_cmd        i_cmd,
    input  logic             i_token_in,
    input  logic             i_last,
    input  logic [COL_W-1:0] i_col_chain,
    output logic             o_pass_fwd,
    output logic             o_pass_wrap,
    output logic [COL_W-1:0] o_col_chain,
    output logic [COL_W-1:0] o_colour,
    output logic             o_token
);

    logic [COL_W-1:0] r_colour;
    logic [COL_W-1:0] n_colour;
    logic             r_token;
    logic             n_token;
    logic             w_pass;

    assign w_pass = r_token && (i_cmd.op == OP_RED_PASS);

    always_comb begin
        n_colour = r_colour;
        if (r_token) begin
            unique case (i_cmd.op)
                OP_ADVANCE:  n_colour = r_colour + 2'd1;
                OP_RED_PASS: n_colour = COL_RED;
                OP_GREEN:    n_colour = COL_GREEN;
                default:     n_colour = r_colour;
            endcase
        end
        n_token = (r_token && !w_pass) || i_token_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour <= COL_RED;
            r_token  <= HOME;
        end else begin
            r_colour <= n_colour;
            r_token  <= n_token;
        end
    end

    assign o_pass_fwd  = w_pass && !i_last;
    assign o_pass_wrap = w_pass && i_last;
    assign o_col_chain = i_col_chain | (r_token ? r_colour : COL_RED);
    assign o_colour    = r_colour;
    assign o_token     = r_token;

endmodule

@@ src/tlrs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic light ring controller
// Registers, phase timer, sequencing state machine and the result register.
// ----------------------------------------------------------------------------
`include "traffic_light_ring_sequencer_macros.svh"

module tlrs_ctrl
    import tlrs_pkg::*;
#(
    parameter int MAX_LIGHTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic [IDX_W-1:0]     i_target,
    output t_cell_cmd            o_cmd,
    input  logic [COL_W-1:0]     i_active_colour,
    input  logic [PACK_W-1:0]    i_colours,
    output logic [LEN_W-1:0]     o_ring_len,
    output logic [IDX_W-1:0]     o_active_light,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PACK_W-1:0]    o_out_colours,
    output logic [IDX_W-1:0]     o_out_active,
    output logic                 o_out_bad
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LIGHTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADV,
        S_WALK,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_light_count, n_light_count;
    logic [PHASE_W-1:0]  r_short, n_short;
    logic [PHASE_W-1:0]  r_long, n_long;
    logic                r_action, n_action;
    logic [IDX_W-1:0]    r_target, n_target;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [IDX_W-1:0]    r_active, n_active;
    logic                r_pending, n_pending;
    logic                r_use_long, n_use_long;
    logic                r_bad, n_bad;
    logic                r_out_valid, n_out_valid;
    logic [PACK_W-1:0]   r_out_colours, n_out_colours;
    logic [IDX_W-1:0]    r_out_active, n_out_active;
    logic                r_out_bad, n_out_bad;

    logic [LEN_W-1:0]    w_ring_len;
    logic [PHASE_W-1:0]  w_limit_raw;
    logic [PHASE_W-1:0]  w_limit;
    logic                w_match;
    logic [LEN_W-1:0]    w_succ;
    logic [IDX_W-1:0]    w_next_active;
    logic [COL_W-1:0]    w_adv_colour;
    t_cell_cmd           w_cmd;

    // A light count of zero behaves as one, anything above the cell count as
    // the cell count.
    assign w_ring_len = (r_light_count == '0) ? LEN_W'(1) :
                        (r_light_count > MAX_LEN) ? MAX_LEN : r_light_count;

    assign w_limit_raw   = r_use_long ? r_long : r_short;
    assign w_limit       = (w_limit_raw == '0) ? PHASE_W'(1) : w_limit_raw;
    assign w_match       = (r_phase == w_limit);
    assign w_succ        = {1'b0, r_active} + LEN_W'(1);
    assign w_next_active = (w_succ >= w_ring_len) ? '0 : w_succ[IDX_W-1:0];
    assign w_adv_colour  = i_active_colour + 2'd1;

    always_comb begin
        n_state       = r_state;
        n_light_count = r_light_count;
        n_short       = r_short;
        n_long        = r_long;
        n_action      = r_action;
        n_target      = r_target;
        n_phase       = r_phase;
        n_active      = r_active;
        n_pending     = r_pending;
        n_use_long    = r_use_long;
        n_bad         = r_bad;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_colours = r_out_colours;
        n_out_active  = r_out_active;
        n_out_bad     = r_out_bad;
        w_cmd.op      = OP_NONE;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIGHT_COUNT: n_light_count = i_cfg_data[LEN_W-1:0];
                CFG_SHORT_TICKS: n_short       = i_cfg_data[PHASE_W-1:0];
                CFG_LONG_TICKS:  n_long        = i_cfg_data[PHASE_W-1:0];
                default:         ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action = i_action;
                    n_target = i_target;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_action == ACT_TICK) begin
                    n_bad = 1'b0;
                    if (w_match) begin
                        if (r_pending) begin
                            // The amber light goes red and hands the token on.
                            w_cmd.op  = OP_RED_PASS;
                            n_pending = 1'b0;
                            n_active  = w_next_active;
                        end
                        n_state = S_ADV;
                    end else begin
                        n_phase = r_phase + PHASE_W'(1);
                        n_state = S_DONE;
                    end
                end else if ({1'b0, r_target} >= w_ring_len) begin
                    n_bad   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_bad   = 1'b0;
                    n_state = S_WALK;
                end
            end
            S_ADV: begin
                w_cmd.op = OP_ADVANCE;
                if (w_adv_colour == COL_GREEN) begin
                    n_use_long = 1'b1;
                end
                if (w_adv_colour == COL_AMBER) begin
                    n_pending  = 1'b1;
                    n_use_long = 1'b0;
                end
                // Counter cleared on the action, then counted for this tick.
                n_phase = PHASE_W'(1);
                n_state = S_DONE;
            end
            S_WALK: begin
                if (r_active == r_target) begin
                    w_cmd.op   = OP_GREEN;
                    n_pending  = 1'b0;
                    n_phase    = '0;
                    n_use_long = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    w_cmd.op = OP_RED_PASS;
                    n_active = w_next_active;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_colours = i_colours;
                    n_out_active  = r_active;
                    n_out_bad     = r_bad;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_light_count <= RST_LIGHT_COUNT;
            r_short       <= RST_SHORT_TICKS;
            r_long        <= RST_LONG_TICKS;
            r_phase       <= '0;
            r_active      <= '0;
            r_pending     <= 1'b0;
            r_use_long    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_light_count <= n_light_count;
            r_short       <= n_short;
            r_long        <= n_long;
            r_phase       <= n_phase;
            r_active      <= n_active;
            r_pending     <= n_pending;
            r_use_long    <= n_use_long;
            r_out_valid   <= n_out_valid;
        end
        r_action      <= n_action;
        r_target      <= n_target;
        r_bad         <= n_bad;
        r_out_colours <= n_out_colours;
        r_out_active  <= n_out_active;
        r_out_bad     <= n_out_bad;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd          = w_cmd;
    assign o_ring_len     = w_ring_len;
    assign o_active_light = r_active;
    assign o_out_valid    = r_out_valid;
    assign o_out_colours  = r_out_colours;
    assign o_out_active   = r_out_active;
    assign o_out_bad      = r_out_bad;

    `TLRS_ASSERT_NEXT(a_adv_restarts_count, i_clk, i_rst_n, r_state == S_ADV, r_phase == PHASE_W'(1), "phase counter not restarted after an action")
    `TLRS_ASSERT_NEXT(a_walk_moves_token, i_clk, i_rst_n, (r_state == S_WALK) && (r_active != r_target), r_active != $past(r_active), "switch walk did not move the active light")
    `TLRS_ASSERT_ALWAYS(a_pending_short_limit, i_clk, i_rst_n, !r_pending || !r_use_long, "amber step pending while the long limit is selected")

endmodule

@@ src/traffic_light_ring_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic light ring sequencer
// Steps a ring of lights, one active at a time, through red, red-and-amber,
// green and amber, and switches the ring to a chosen light on request.
// ----------------------------------------------------------------------------
//
// Channel   Direction  tdata (low bit up)                     tuser
// s_axis    in         target_light[3:0], zero pad to 8 bits   action
// m_axis    out        colours_packed[31:0], active_index[3:0],
//                      zero pad to 40 bits                     bad_target
// cfg       in         i_cfg_idx selects the register, i_cfg_data the value
//
// One transfer in produces exactly one transfer out. A tick passes from
// acceptance through the execute state, the advance state when the phase
// limit is met, and the done state, which registers its result. A switch
// passes through execute, the walk state, which moves the token light by
// light to the target and turns it green, and done; a refused switch skips
// the walk. The walk is bounded by the token ring: the active token moves
// one cell per cycle. The result waits in an output register, so a new item
// is taken while it is still unclaimed; a stalled output holds the block
// only when the next result is ready. Reset is synchronous and active low:
// all lights red, light 0 active, registers at their defaults.
//
// Each cell holds one light's colour and a token bit; the token marks the
// active light and moves from cell to cell, wrapping to cell 0 after the
// last light of the ring. The controller broadcasts one operation per
// cycle, which only the token holder applies.
// ----------------------------------------------------------------------------
`include "traffic_light_ring_sequencer_macros.svh"

module traffic_light_ring_sequencer
    import tlrs_pkg::*;
#(
    parameter int MAX_LIGHTS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration writes.
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // target_light[3:0], pad
    input  logic                   s_axis_tuser,   // action
    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // colours_packed, active_index, pad
    output logic                   m_axis_tuser    // bad_target
);

    t_cell_cmd              w_cmd;
    logic [LEN_W-1:0]       w_ring_len;
    logic [IDX_W-1:0]       w_active;
    logic [MAX_LIGHTS-1:0]  w_token;
    logic [MAX_LIGHTS-1:0]  w_token_in;
    logic [MAX_LIGHTS-1:0]  w_pass_fwd;
    logic [MAX_LIGHTS-1:0]  w_pass_wrap;
    logic [MAX_LIGHTS-1:0]  w_last;
    logic [COL_W-1:0]       w_chain [MAX_LIGHTS+1];
    logic [COL_W-1:0]       w_colour [MAX_LIGHTS];
    logic [PACK_W-1:0]      w_colours;
    logic [PACK_W-1:0]      w_out_colours;
    logic [IDX_W-1:0]       w_out_active;

    // The colour of the token holder ripples down the row; empty cells add
    // nothing to it.
    assign w_chain[0] = COL_RED;

    // A token passed from the last light of the ring returns to cell 0.
    assign w_token_in[0] = |w_pass_wrap;

    genvar g;
    generate
        for (g = 0; g < MAX_LIGHTS; g++) begin : g_cell
            assign w_last[g] = (LEN_W'(g + 1) >= w_ring_len);

            if (g > 0) begin : g_link
                assign w_token_in[g] = w_pass_fwd[g-1];
            end

            tlrs_cell #(
                .HOME (g == 0)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_token_in  (w_token_in[g]),
                .i_last      (w_last[g]),
                .i_col_chain (w_chain[g]),
                .o_pass_fwd  (w_pass_fwd[g]),
                .o_pass_wrap (w_pass_wrap[g]),
                .o_col_chain (w_chain[g+1]),
                .o_colour    (w_colour[g]),
                .o_token     (w_token[g])
            );
        end

        // Light i occupies bits 2i+1..2i; slots without a cell read red.
        for (g = 0; g < PACK_W / COL_W; g++) begin : g_pack
            if (g < MAX_LIGHTS) begin : g_used
                assign w_colours[g*COL_W +: COL_W] = w_colour[g];
            end else begin : g_unused
                assign w_colours[g*COL_W +: COL_W] = COL_RED;
            end
        end
    endgenerate

    tlrs_ctrl #(
        .MAX_LIGHTS (MAX_LIGHTS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_action        (s_axis_tuser),
        .i_target        (s_axis_tdata[IDX_W-1:0]),
        .o_cmd           (w_cmd),
        .i_active_colour (w_chain[MAX_LIGHTS]),
        .i_colours       (w_colours),
        .o_ring_len      (w_ring_len),
        .o_active_light  (w_active),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_out_colours   (w_out_colours),
        .o_out_active    (w_out_active),
        .o_out_bad       (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - PACK_W - IDX_W){1'b0}}, w_out_active, w_out_colours};

    // Token and controller index must name the same light. At reset the
    // token sits in cell 0, so the first check also covers the reset value.
    `TLRS_ASSERT_ALWAYS(a_token_onehot, i_clk, i_rst_n, $onehot(w_token), "active token lost or duplicated")
    `TLRS_ASSERT_ALWAYS(a_token_matches_index, i_clk, i_rst_n, w_token == (MAX_LIGHTS'(1) << w_active), "token cell differs from active index")
    `TLRS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "new item taken while one is in progress")

endmodule
